### design/tfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tfc_pkg;

  localparam int HEADER_BYTES = 36;

  localparam logic [31:0] MIN_LEN    = 32'(HEADER_BYTES + 8);
  localparam logic [31:0] LINK_POS   = 32'(HEADER_BYTES);
  localparam logic [31:0] LINK_END   = 32'(HEADER_BYTES + 4);
  localparam logic [31:0] APP_HI_POS = 32'(HEADER_BYTES + 4);
  localparam logic [31:0] APP_LO_POS = 32'(HEADER_BYTES + 5);
  localparam logic [31:0] PLEN_MIN   = 32'd8;

  localparam logic [31:0] PREAMBLE  = 32'hA1B2_C3D4;
  localparam logic [31:0] POSTAMBLE = ~PREAMBLE;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
  localparam logic [2:0] ST_BAD_PRE    = 3'd2;
  localparam logic [2:0] ST_BAD_LEN    = 3'd3;
  localparam logic [2:0] ST_INCOMPLETE = 3'd4;
  localparam logic [2:0] ST_PAY_SHORT  = 3'd5;
  localparam logic [2:0] ST_UNKNOWN_ID = 3'd6;

  localparam logic [1:0] CLS_NONE   = 2'd0;
  localparam logic [1:0] CLS_BEACON = 2'd1;
  localparam logic [1:0] CLS_REPORT = 2'd2;

  localparam logic [7:0] CFG_CRC_EN    = 8'd0;
  localparam logic [7:0] CFG_TLM_TYPE  = 8'd1;
  localparam logic [7:0] CFG_BEACON_ID = 8'd2;
  localparam logic [7:0] CFG_REPORT_ID = 8'd3;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] place(input logic [31:0] word, input logic [1:0] off,
                                        input logic [7:0] b);
    return word | ({24'd0, b} << {off, 3'b000});
  endfunction

endpackage

`default_nettype wire

### design/telemetry_frame_checker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// a last byte reaches its out_ verdict through the input register and then the result register
// throughput: one byte per cycle, set by the byte-wide crc update between input and result register
// a byte with last set waits in the input register only while an unread verdict is stalled
// reset (rst_n low, synchronous) clears frame state, empties both registers, restores config
module telemetry_frame_checker_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [1:0]       out_msg_class,
  output logic             out_crc_mismatch,
  output logic             out_postamble_bad,
  output logic             out_type_unsupported,
  output logic [31:0]      out_frame_length,
  output logic [31:0]      out_payload_length,
  output logic [31:0]      out_link_id,
  output logic [15:0]      out_app_msg_id,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic        in_v_r;
  logic [7:0]  byte_r;
  logic        last_r;

  logic        crc_en_r;
  logic [31:0] tlm_type_r;
  logic [15:0] beacon_id_r;
  logic [15:0] report_id_r;

  logic [31:0] count_r, count_nxt;
  logic [31:0] pre_r, pre_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] type_r, type_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] rx_crc_r, rx_crc_nxt;
  logic [31:0] trail_r, trail_nxt;
  logic [31:0] link_r, link_nxt;
  logic [15:0] app_r, app_nxt;

  logic        out_valid_r;
  logic [2:0]  status_r, status_nxt;
  logic [1:0]  cls_r, cls_nxt;
  logic        crcbad_r, crcbad_nxt;
  logic        postbad_r, postbad_nxt;
  logic        typebad_r, typebad_nxt;
  logic [31:0] flen_r, flen_nxt;
  logic [31:0] plen_r, plen_nxt;
  logic [31:0] link_out_r, link_out_nxt;
  logic [15:0] app_out_r, app_out_nxt;

  logic        out_free;
  logic        proc;
  logic        accept;
  logic [1:0]  tail_off;
  logic [31:0] plen_calc;

  assign out_free  = !out_valid_r || !out_stall;
  assign proc      = in_v_r && (!last_r || out_free);
  assign in_stall  = in_v_r && !proc;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
    if (accept) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  // frame state update for the byte in the input register
  always_comb begin
    pre_nxt    = pre_r;
    len_nxt    = len_r;
    type_nxt   = type_r;
    crc_nxt    = crc_r;
    rx_crc_nxt = rx_crc_r;
    trail_nxt  = trail_r;
    link_nxt   = link_r;
    app_nxt    = app_r;
    tail_off   = count_r[1:0] - len_r[1:0];

    if (count_r < 32'd4) begin
      pre_nxt = tfc_pkg::place(pre_r, count_r[1:0], byte_r);
    end else if (count_r < 32'd8) begin
      len_nxt = tfc_pkg::place(len_r, count_r[1:0], byte_r);
    end else if (count_r < 32'd12) begin
      type_nxt = tfc_pkg::place(type_r, count_r[1:0], byte_r);
    end

    if (count_r < 32'd8) begin
      crc_nxt = tfc_pkg::crc_byte(crc_r, byte_r);
    end else if (len_r >= 32'd8) begin
      if (count_r < len_r - 32'd8) begin
        crc_nxt = tfc_pkg::crc_byte(crc_r, byte_r);
      end else if (count_r < len_r - 32'd4) begin
        rx_crc_nxt = tfc_pkg::place(rx_crc_r, tail_off, byte_r);
      end else if (count_r < len_r) begin
        trail_nxt = tfc_pkg::place(trail_r, tail_off, byte_r);
      end
    end

    if (count_r >= tfc_pkg::LINK_POS && count_r < tfc_pkg::LINK_END) begin
      link_nxt = tfc_pkg::place(link_r, count_r[1:0] - tfc_pkg::LINK_POS[1:0], byte_r);
    end else if (count_r == tfc_pkg::APP_HI_POS) begin
      app_nxt = {byte_r, app_r[7:0]};
    end else if (count_r == tfc_pkg::APP_LO_POS) begin
      app_nxt = {app_r[15:8], byte_r};
    end

    count_nxt = (count_r == tfc_pkg::ALL_ONES) ? count_r : count_r + 32'd1;
  end

  // verdict from the state after this byte
  always_comb begin
    status_nxt   = tfc_pkg::ST_TOO_SHORT;
    cls_nxt      = tfc_pkg::CLS_NONE;
    crcbad_nxt   = 1'b0;
    postbad_nxt  = 1'b0;
    typebad_nxt  = 1'b0;
    flen_nxt     = 32'd0;
    plen_nxt     = 32'd0;
    link_out_nxt = 32'd0;
    app_out_nxt  = 16'd0;
    plen_calc    = len_nxt - tfc_pkg::MIN_LEN;

    if (count_nxt >= tfc_pkg::MIN_LEN) begin
      flen_nxt = len_nxt;
      if (pre_nxt != tfc_pkg::PREAMBLE) begin
        status_nxt = tfc_pkg::ST_BAD_PRE;
      end else begin
        typebad_nxt = (type_nxt != tlm_type_r);
        if (len_nxt < tfc_pkg::MIN_LEN) begin
          status_nxt = tfc_pkg::ST_BAD_LEN;
        end else if (count_nxt < len_nxt) begin
          status_nxt = tfc_pkg::ST_INCOMPLETE;
        end else begin
          plen_nxt    = plen_calc;
          crcbad_nxt  = crc_en_r && (rx_crc_nxt != ~crc_nxt);
          postbad_nxt = (trail_nxt != tfc_pkg::POSTAMBLE);
          if (plen_calc < tfc_pkg::PLEN_MIN) begin
            status_nxt = tfc_pkg::ST_PAY_SHORT;
          end else begin
            link_out_nxt = link_nxt;
            app_out_nxt  = app_nxt;
            if (app_nxt == beacon_id_r) begin
              status_nxt = tfc_pkg::ST_OK;
              cls_nxt    = tfc_pkg::CLS_BEACON;
            end else if (app_nxt == report_id_r) begin
              status_nxt = tfc_pkg::ST_OK;
              cls_nxt    = tfc_pkg::CLS_REPORT;
            end else begin
              status_nxt = tfc_pkg::ST_UNKNOWN_ID;
            end
          end
        end
      end
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_en_r    <= 1'b1;
      tlm_type_r  <= 32'd0;
      beacon_id_r <= 16'd0;
      report_id_r <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tfc_pkg::CFG_CRC_EN:    crc_en_r    <= cfg_data[0];
        tfc_pkg::CFG_TLM_TYPE:  tlm_type_r  <= cfg_data;
        tfc_pkg::CFG_BEACON_ID: beacon_id_r <= cfg_data[15:0];
        tfc_pkg::CFG_REPORT_ID: report_id_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // frame state, cleared after each verdict
  always_ff @(posedge clk) begin
    if (!rst_n || (proc && last_r)) begin
      count_r  <= 32'd0;
      pre_r    <= 32'd0;
      len_r    <= 32'd0;
      type_r   <= 32'd0;
      crc_r    <= tfc_pkg::ALL_ONES;
      rx_crc_r <= 32'd0;
      trail_r  <= 32'd0;
      link_r   <= 32'd0;
      app_r    <= 16'd0;
    end else if (proc) begin
      count_r  <= count_nxt;
      pre_r    <= pre_nxt;
      len_r    <= len_nxt;
      type_r   <= type_nxt;
      crc_r    <= crc_nxt;
      rx_crc_r <= rx_crc_nxt;
      trail_r  <= trail_nxt;
      link_r   <= link_nxt;
      app_r    <= app_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= proc && last_r;
    end
    if (proc && last_r) begin
      status_r   <= status_nxt;
      cls_r      <= cls_nxt;
      crcbad_r   <= crcbad_nxt;
      postbad_r  <= postbad_nxt;
      typebad_r  <= typebad_nxt;
      flen_r     <= flen_nxt;
      plen_r     <= plen_nxt;
      link_out_r <= link_out_nxt;
      app_out_r  <= app_out_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_msg_class        = cls_r;
  assign out_crc_mismatch     = crcbad_r;
  assign out_postamble_bad    = postbad_r;
  assign out_type_unsupported = typebad_r;
  assign out_frame_length     = flen_r;
  assign out_payload_length   = plen_r;
  assign out_link_id          = link_out_r;
  assign out_app_msg_id       = app_out_r;

endmodule

`default_nettype wire

### design/tfc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tfc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic [1:0]  out_msg_class,
  input wire logic        out_crc_mismatch,
  input wire logic        out_postamble_bad,
  input wire logic        out_type_unsupported,
  input wire logic [31:0] out_frame_length,
  input wire logic [31:0] out_payload_length,
  input wire logic [31:0] out_link_id,
  input wire logic [15:0] out_app_msg_id
);

  // a stalled verdict holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_msg_class)
      && $stable(out_frame_length) && $stable(out_app_msg_id))
    else $error("stalled verdict changed");

  // input only backs up behind a stalled verdict
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled with no verdict waiting");

  // class is set exactly on a good verdict
  a_class_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == tfc_pkg::ST_OK) == (out_msg_class != tfc_pkg::CLS_NONE)))
    else $error("class disagrees with status");

  // short buffer reports no header fields
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tfc_pkg::ST_TOO_SHORT |->
      out_frame_length == 32'd0 && !out_type_unsupported && !out_crc_mismatch)
    else $error("short buffer with header fields");

  // payload fields only once the preamble and length checks pass
  a_early_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == tfc_pkg::ST_BAD_PRE || out_status == tfc_pkg::ST_BAD_LEN
      || out_status == tfc_pkg::ST_INCOMPLETE) |->
      out_payload_length == 32'd0 && !out_postamble_bad && out_link_id == 32'd0)
    else $error("payload fields on early failure");

endmodule

bind telemetry_frame_checker_core tfc_checker u_tfc_checker (.*);

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tfc_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  msg_class;
    logic        crc_mismatch;
    logic        postamble_bad;
    logic        type_unsupported;
    logic [31:0] frame_length;
    logic [31:0] payload_length;
    logic [31:0] link_id;
    logic [15:0] app_msg_id;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [1:0]  out_msg_class;
  logic        out_crc_mismatch;
  logic        out_postamble_bad;
  logic        out_type_unsupported;
  logic [31:0] out_frame_length;
  logic [31:0] out_payload_length;
  logic [31:0] out_link_id;
  logic [15:0] out_app_msg_id;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'h00;
  logic [31:0] cfg_data = 32'h0;

  // shadow copy of the configuration registers
  logic        cfg_crc_on = 1'b1;
  logic [31:0] cfg_tlm_type = 32'h0;
  logic [15:0] cfg_beacon = 16'h0;
  logic [15:0] cfg_report = 16'h0;

  // shadow copy of the frame state
  logic [31:0] rx_count = 32'h0;
  logic [31:0] rx_pre = 32'h0;
  logic [31:0] rx_len = 32'h0;
  logic [31:0] rx_type = 32'h0;
  logic [31:0] rx_crc = ALL_ONES;
  logic [31:0] rx_fcs = 32'h0;
  logic [31:0] rx_trail = 32'h0;
  logic [31:0] rx_link = 32'h0;
  logic [15:0] rx_app = 16'h0;

  verdict_t    verdicts_due[$];
  verdict_t    due;
  logic [7:0]  frame_q[$];
  int          fail_count = 0;
  int          bytes_sent = 0;
  int          stall_hold = 0;
  bit          no_gaps = 1'b0;

  telemetry_frame_checker_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_msg_class        (out_msg_class),
    .out_crc_mismatch     (out_crc_mismatch),
    .out_postamble_bad    (out_postamble_bad),
    .out_type_unsupported (out_type_unsupported),
    .out_frame_length     (out_frame_length),
    .out_payload_length   (out_payload_length),
    .out_link_id          (out_link_id),
    .out_app_msg_id       (out_app_msg_id),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int pace();
    return no_gaps ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'h0, b};
    repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    return r;
  endfunction

  function automatic logic [31:0] put_lane(input logic [31:0] w, input logic [1:0] lane,
                                           input logic [7:0] b);
    return w | ({24'h0, b} << (8 * lane));
  endfunction

  function automatic void note_config(input logic [7:0] idx, input logic [31:0] data);
    case (idx)
      CFG_CRC_EN:    cfg_crc_on = data[0];
      CFG_TLM_TYPE:  cfg_tlm_type = data;
      CFG_BEACON_ID: cfg_beacon = data[15:0];
      CFG_REPORT_ID: cfg_report = data[15:0];
      default: ;
    endcase
  endfunction

  // tracks one accepted byte and queues the verdict a last byte produces
  function automatic void advance_frame(input logic [7:0] b, input logic last);
    logic [31:0] p;
    logic [31:0] off;
    verdict_t    v;
    p = rx_count;
    if (p < 4) rx_pre = put_lane(rx_pre, p[1:0], b);
    else if (p < 8) rx_len = put_lane(rx_len, p[1:0], b);
    else if (p < 12) rx_type = put_lane(rx_type, p[1:0], b);

    if (p < 8) begin
      rx_crc = crc_step(rx_crc, b);
    end else if (rx_len >= 8) begin
      off = p - rx_len;
      if (p < rx_len - 8) rx_crc = crc_step(rx_crc, b);
      else if (p < rx_len - 4) rx_fcs = put_lane(rx_fcs, off[1:0], b);
      else if (p < rx_len) rx_trail = put_lane(rx_trail, off[1:0], b);
    end

    if (p >= LINK_POS && p < LINK_END) begin
      off = p - LINK_POS;
      rx_link = put_lane(rx_link, off[1:0], b);
    end else if (p == APP_HI_POS) begin
      rx_app[15:8] = b;
    end else if (p == APP_LO_POS) begin
      rx_app[7:0] = b;
    end

    if (rx_count != ALL_ONES) rx_count = rx_count + 1;
    if (!last) return;

    v = '0;
    if (rx_count < MIN_LEN) begin
      v.status = ST_TOO_SHORT;
    end else begin
      v.frame_length = rx_len;
      if (rx_pre != PREAMBLE) begin
        v.status = ST_BAD_PRE;
      end else begin
        v.type_unsupported = (rx_type != cfg_tlm_type);
        if (rx_len < MIN_LEN) begin
          v.status = ST_BAD_LEN;
        end else if (rx_count < rx_len) begin
          v.status = ST_INCOMPLETE;
        end else begin
          v.payload_length = rx_len - MIN_LEN;
          v.crc_mismatch = cfg_crc_on && (rx_fcs != ~rx_crc);
          v.postamble_bad = (rx_trail != POSTAMBLE);
          if (v.payload_length < PLEN_MIN) begin
            v.status = ST_PAY_SHORT;
          end else begin
            v.link_id = rx_link;
            v.app_msg_id = rx_app;
            if (rx_app == cfg_beacon) begin
              v.status = ST_OK;
              v.msg_class = CLS_BEACON;
            end else if (rx_app == cfg_report) begin
              v.status = ST_OK;
              v.msg_class = CLS_REPORT;
            end else begin
              v.status = ST_UNKNOWN_ID;
            end
          end
        end
      end
    end
    verdicts_due.push_back(v);

    rx_count = 32'h0;
    rx_pre = 32'h0;
    rx_len = 32'h0;
    rx_type = 32'h0;
    rx_crc = ALL_ONES;
    rx_fcs = 32'h0;
    rx_trail = 32'h0;
    rx_link = 32'h0;
    rx_app = 16'h0;
  endfunction

  function automatic void push_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) frame_q.push_back(w[8*k +: 8]);
  endfunction

  function automatic void set_len_field(input logic [31:0] w);
    for (int k = 0; k < 4; k++) frame_q[4 + k] = w[8*k +: 8];
  endfunction

  function automatic void build_frame(input int plen, input logic [31:0] ftype,
                                      input logic [31:0] link, input logic [15:0] app,
                                      input bit crc_ok, input bit post_ok);
    logic [31:0] crc;
    logic [31:0] trail;
    frame_q.delete();
    push_word(PREAMBLE);
    push_word(MIN_LEN + plen);
    push_word(ftype);
    while (frame_q.size() < HEADER_BYTES) frame_q.push_back(8'($urandom));
    for (int i = 0; i < plen; i++) begin
      if (i < 4) frame_q.push_back(link[8*i +: 8]);
      else if (i == 4) frame_q.push_back(app[15:8]);
      else if (i == 5) frame_q.push_back(app[7:0]);
      else frame_q.push_back(8'($urandom));
    end
    crc = ALL_ONES;
    foreach (frame_q[i]) crc = crc_step(crc, frame_q[i]);
    crc = ~crc;
    if (!crc_ok) crc = crc ^ ($urandom | 32'h1);
    push_word(crc);
    trail = POSTAMBLE;
    if (!post_ok) trail = trail ^ (32'h1 << $urandom_range(0, 31));
    push_word(trail);
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pace();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    advance_frame(b, last);
    bytes_sent++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // stop sending and wait for every outstanding verdict
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [7:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    note_config(idx, data);
  endtask

  // upper data bits are junk and must be masked off by the block
  task automatic apply_config(input logic en, input logic [31:0] ttype,
                              input logic [15:0] bid, input logic [15:0] rid);
    cfg_write(CFG_CRC_EN, {31'($urandom), en});
    cfg_write(CFG_TLM_TYPE, ttype);
    cfg_write(CFG_BEACON_ID, {16'($urandom), bid});
    cfg_write(CFG_REPORT_ID, {16'($urandom), rid});
    cfg_write(8'($urandom_range(CFG_REPORT_ID + 1, 255)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_short_buffers();
    settle(4);
    apply_config(1'b1, 32'h1234_5678, 16'h0042, 16'h0105);
    frame_q.delete();
    frame_q.push_back(8'h00);
    send_buffer();
    frame_q.delete();
    frame_q.push_back(8'hFF);
    send_buffer();
    build_frame(8, cfg_tlm_type, $urandom, cfg_beacon, 1, 1);
    while (frame_q.size() > MIN_LEN - 1) void'(frame_q.pop_back());
    send_buffer();
  endtask

  task automatic test_header_checks();
    build_frame(8, cfg_tlm_type, $urandom, cfg_beacon, 1, 1);
    frame_q[0] = frame_q[0] ^ 8'h01;
    send_buffer();
    build_frame(8, ~cfg_tlm_type, $urandom, cfg_beacon, 1, 1);
    set_len_field(32'h0);
    send_buffer();
    build_frame(8, cfg_tlm_type, $urandom, cfg_beacon, 1, 1);
    set_len_field(MIN_LEN - 1);
    send_buffer();
    // length below the size of the crc and postamble words
    build_frame(0, cfg_tlm_type, $urandom, cfg_beacon, 1, 1);
    set_len_field(32'd7);
    send_buffer();
    build_frame(8, cfg_tlm_type, $urandom, cfg_beacon, 1, 1);
    set_len_field(ALL_ONES);
    send_buffer();
    build_frame(8, cfg_tlm_type, $urandom, cfg_beacon, 1, 1);
    void'(frame_q.pop_back());
    send_buffer();
  endtask

  task automatic test_payload_checks();
    logic [15:0] odd_id;
    build_frame(0, cfg_tlm_type, $urandom, cfg_beacon, 1, 1);
    send_buffer();
    build_frame(7, cfg_tlm_type, $urandom, cfg_beacon, 1, 1);
    send_buffer();
    do odd_id = 16'($urandom); while (odd_id == cfg_beacon || odd_id == cfg_report);
    build_frame(8, cfg_tlm_type, $urandom, odd_id, 1, 1);
    send_buffer();
    build_frame(8, cfg_tlm_type, $urandom, cfg_beacon, 1, 1);
    send_buffer();
    build_frame(30, cfg_tlm_type, $urandom, cfg_report, 1, 1);
    send_buffer();
    // equal ids resolve to beacon
    settle(4);
    apply_config(1'b1, ALL_ONES, 16'hFFFF, 16'hFFFF);
    build_frame(8, ALL_ONES, ALL_ONES, 16'hFFFF, 1, 1);
    send_buffer();
  endtask

  task automatic test_trailer_flags();
    build_frame(12, cfg_tlm_type, $urandom, cfg_report, 0, 1);
    send_buffer();
    build_frame(12, cfg_tlm_type, $urandom, cfg_report, 1, 0);
    send_buffer();
    build_frame(12, 32'h0, $urandom, cfg_report, 1, 1);
    send_buffer();
    // bytes beyond the length in the length field are ignored
    build_frame(9, cfg_tlm_type, $urandom, cfg_beacon, 1, 1);
    repeat (5) frame_q.push_back(8'($urandom));
    send_buffer();
    settle(4);
    apply_config(1'b0, 32'h0, 16'h0000, 16'hFFFF);
    build_frame(10, 32'h0, 32'h0, 16'h0000, 0, 0);
    send_buffer();
  endtask

  task automatic random_buffer();
    int          kind;
    int          plen;
    int          cut;
    logic [15:0] app;
    kind = $urandom_range(0, 99);
    plen = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 200) : $urandom_range(8, 24);
    case ($urandom_range(0, 2))
      0: app = cfg_beacon;
      1: app = cfg_report;
      default: app = 16'($urandom);
    endcase
    build_frame(plen, ($urandom_range(0, 4) == 0) ? $urandom : cfg_tlm_type, $urandom, app,
                $urandom_range(0, 4) != 0, $urandom_range(0, 6) != 0);
    if (kind < 60) begin
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
    end else if (kind < 80) begin
      case ($urandom_range(0, 3))
        0: begin
          cut = $urandom_range(1, frame_q.size() - 1);
          while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
        1: frame_q[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
        2: set_len_field($urandom_range(0, 1) ? $urandom_range(0, 60) : $urandom);
        default: build_frame($urandom_range(0, 7), cfg_tlm_type, $urandom, app, 1, 1);
      endcase
    end else begin
      frame_q.delete();
      if ($urandom_range(0, 1) != 0) push_word(PREAMBLE);
      repeat ($urandom_range(1, 60)) frame_q.push_back(8'($urandom));
    end
    send_buffer();
  endtask

  task automatic test_random_traffic();
    int byte_base;
    int phase;
    byte_base = bytes_sent;
    phase = 0;
    while (bytes_sent - byte_base < 200) begin
      settle(4);
      apply_config($urandom_range(0, 1), pick_word(), 16'(pick_word()), 16'(pick_word()));
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int f = 0; f < 6; f++) begin
        if ((phase == 0 && f == 3) || $urandom_range(0, 15) == 0) settle(0);
        random_buffer();
      end
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  // result side: check every transfer, then stall for a drawn number of cycles
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: verdict with none expected, status %0d", $time, out_status);
        fail_count++;
      end else begin
        due = verdicts_due.pop_front();
        check_field("status", due.status, out_status);
        check_field("msg_class", due.msg_class, out_msg_class);
        check_field("crc_mismatch", due.crc_mismatch, out_crc_mismatch);
        check_field("postamble_bad", due.postamble_bad, out_postamble_bad);
        check_field("type_unsupported", due.type_unsupported, out_type_unsupported);
        check_field("frame_length", due.frame_length, out_frame_length);
        check_field("payload_length", due.payload_length, out_payload_length);
        check_field("link_id", due.link_id, out_link_id);
        check_field("app_msg_id", due.app_msg_id, out_app_msg_id);
      end
      stall_hold = pace();
    end else if (out_valid === 1'b1 && stall_hold > 0) begin
      stall_hold--;
    end
    out_stall <= (stall_hold != 0);
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_short_buffers();
    test_header_checks();
    test_payload_checks();
    test_trailer_flags();
    test_random_traffic();
    settle(8);
    if (fail_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

### files.f
design/tfc_pkg.sv
design/telemetry_frame_checker_core.sv
design/tfc_checker.sv
dv/testbench.sv
